/* design/hre_pkg.sv */
// Shared constants and types for the homography reprojection error block.
// Used by hre_div and homography_reprojection_error_mean; no dependencies.
`timescale 1ns / 1ps

package hre_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = 11;
  localparam int COORD_W    = 20;
  localparam int COEF_W     = 32;
  localparam int ACC_W      = 56;
  localparam int DVD_W      = 64;
  localparam int DVS_W      = 56;
  localparam int QUO_W      = 34;
  localparam int SUM_W      = 48;
  localparam int DIFF_W     = 31;

  localparam logic [COEF_W-1:0] COEF_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [DIFF_W-1:0] DIFF_MAX       = 31'h7FFF_FFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_ROW0_XY  = 3'd0;
  localparam logic [2:0] REG_ROW0_OFF = 3'd1;
  localparam logic [2:0] REG_ROW1_XY  = 3'd2;
  localparam logic [2:0] REG_ROW1_OFF = 3'd3;
  localparam logic [2:0] REG_ROW2_XY  = 3'd4;
  localparam logic [2:0] REG_ROW2_OFF = 3'd5;

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

/* design/hre_div.sv */
// Iterative restoring divider, one quotient bit per clock, with an overflow flag when the quotient would not fit.
// Depends on hre_pkg for widths and the div_stat_t status struct.
`timescale 1ns / 1ps

module hre_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hre_pkg::DVD_W-1:0]    dividend,
  input  logic [hre_pkg::DVS_W-1:0]    divisor,
  output logic [hre_pkg::QUO_W-1:0]    quot,
  output hre_pkg::div_stat_t           stat
);

  localparam int HI_W = hre_pkg::DVD_W - hre_pkg::QUO_W;

  logic                        busy_r;
  logic                        done_r;
  logic                        ovf_r;
  logic [5:0]                  cnt_r;
  logic [hre_pkg::DVS_W-1:0]   rem_r;
  logic [hre_pkg::QUO_W-1:0]   dvd_r;
  logic [hre_pkg::DVS_W-1:0]   dvs_r;
  logic [hre_pkg::QUO_W-1:0]   quot_r;

  logic [HI_W-1:0]             hi;
  logic [hre_pkg::DVS_W:0]     trial;
  logic                        ge;
  logic [hre_pkg::DVS_W-1:0]   rem_nxt;

  // Upper dividend bits: quotient would not fit when they already reach the divisor
  assign hi      = dividend[hre_pkg::DVD_W-1:hre_pkg::QUO_W];
  assign trial   = {rem_r, dvd_r[hre_pkg::QUO_W-1]};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? hre_pkg::DVS_W'(trial - {1'b0, dvs_r})
                      : trial[hre_pkg::DVS_W-1:0];

  // Load on start, then shift in one dividend bit a clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (hre_pkg::DVS_W'(hi) >= divisor) begin
          ovf_r  <= 1'b1;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          ovf_r  <= 1'b0;
          busy_r <= 1'b1;
          rem_r  <= hre_pkg::DVS_W'(hi);
          dvd_r  <= dividend[hre_pkg::QUO_W-1:0];
          dvs_r  <= divisor;
          cnt_r  <= 6'(hre_pkg::QUO_W - 1);
          quot_r <= '0;
        end
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[hre_pkg::QUO_W-2:0], 1'b0};
        quot_r <= {quot_r[hre_pkg::QUO_W-2:0], ge};
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign quot      = quot_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

/* design/homography_reprojection_error_mean.sv */
// Top level: mean homography reprojection error over a set of correspondences.
// Depends on hre_pkg and hre_div.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one word per correspondence, first
//   point, matched point and a last flag. in_ready is high only while the
//   sequencer is idle; a counted point runs through these steps from one
//   accept to the next: idle, the shared multiplier for the projective
//   sums, the denominator check, two passes of the bit-serial divider,
//   the squares, 32 square root steps, the add and the close.
//   A zero denominator closes the point straight after the check.
//   Points beyond 1024 in a set are dropped.
//   Result channel (out_valid/out_ready): one word per set, after the item
//   marked last; the mean is taken on the same divider (skipped for an
//   invalid set), then loaded into the output register.
//   The result sits in an output register; a new set's points are taken
//   while it waits, and only the next result waits for the receiver.
//   Configuration (cfg_we/cfg_index/cfg_data): write coefficients while
//   idle; unknown indexes are ignored.
//   Reset (synchronous, rst_n low) loads the identity homography and clears
//   the sum, the point count and the bad denominator flag.

module homography_reprojection_error_mean (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hre_pkg::COORD_W-1:0]   in_first_x,
  input  logic [hre_pkg::COORD_W-1:0]   in_first_y,
  input  logic [hre_pkg::COORD_W-1:0]   in_second_x,
  input  logic [hre_pkg::COORD_W-1:0]   in_second_y,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_mean_error,
  output logic                          out_valid_res,
  output logic [hre_pkg::CNT_W-1:0]     out_point_count,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_CHK, ST_DXS, ST_DXW, ST_DYS, ST_DYW, ST_SQA,
    ST_SQB, ST_SQC, ST_SQRT, ST_ACC, ST_END, ST_FIN, ST_MW, ST_OUTW
  } state_t;

  state_t                         state_r;

  // Coefficient registers
  logic [63:0]                    row0_xy_r, row1_xy_r, row2_xy_r;
  logic [31:0]                    row0_off_r, row1_off_r, row2_off_r;

  // Set state
  logic [hre_pkg::SUM_W-1:0]      sum_r;
  logic [hre_pkg::CNT_W-1:0]      pts_r;
  logic                           bad_r;

  // Point working registers
  logic [hre_pkg::COORD_W-1:0]    x_r, y_r, sx_r, sy_r;
  logic                           last_r;
  logic [2:0]                     ms_r;
  logic signed [hre_pkg::ACC_W-1:0] numx_r, numy_r, den_r;
  logic signed [65:0]             prod_r;
  logic [hre_pkg::DIFF_W-1:0]     ax_r, ay_r;
  logic [62:0]                    sq_r;
  logic [63:0]                    v_r, root_r, bit_r;
  logic [31:0]                    mean_r;
  logic                           vres_r;

  // Output register
  logic                           out_valid_r;
  logic [31:0]                    out_mean_r;
  logic                           out_vres_r;
  logic [hre_pkg::CNT_W-1:0]      out_cnt_r;

  // Shared multiplier
  logic [63:0]                    row_sel;
  logic [31:0]                    coef_sel;
  logic [hre_pkg::COORD_W-1:0]    coord_sel;
  logic signed [32:0]             mul_a, mul_b;
  logic signed [65:0]             prod;
  logic [2:0]                     add_idx;
  logic signed [hre_pkg::ACC_W-1:0] acc_sum;

  // Divider hookup
  logic                           div_start;
  logic [hre_pkg::DVD_W-1:0]      div_dvd;
  logic [hre_pkg::DVS_W-1:0]      div_dvs;
  logic [hre_pkg::QUO_W-1:0]      div_quot;
  hre_pkg::div_stat_t             div_st;
  logic [hre_pkg::ACC_W-1:0]      absx, absy, absd;

  logic                           fin_ok;
  logic [63:0]                    sq_trial;
  logic [hre_pkg::SUM_W:0]        sum_ext;

  // Saturated magnitude of target minus the signed quotient
  function automatic logic [hre_pkg::DIFF_W-1:0] diff_mag(
    input logic [hre_pkg::COORD_W-1:0] tgt,
    input logic [hre_pkg::QUO_W-1:0]   q,
    input logic                        ovf,
    input logic                        neg
  );
    logic [35:0] qs;
    logic [35:0] d;
    logic [35:0] m;
    qs = neg ? (36'd0 - {2'b0, q}) : {2'b0, q};
    d  = {16'b0, tgt} - qs;
    m  = d[35] ? (36'd0 - d) : d;
    if (ovf || m > {5'b0, hre_pkg::DIFF_MAX}) begin
      return hre_pkg::DIFF_MAX;
    end
    return m[hre_pkg::DIFF_W-1:0];
  endfunction

  // Pick multiplier operands for the current step
  always_comb begin
    case (ms_r[2:1])
      2'd0:    row_sel = row0_xy_r;
      2'd1:    row_sel = row1_xy_r;
      default: row_sel = row2_xy_r;
    endcase
    coef_sel  = ms_r[0] ? row_sel[63:32] : row_sel[31:0];
    coord_sel = ms_r[0] ? y_r : x_r;
    case (state_r)
      ST_MUL: begin
        mul_a = {coef_sel[31], coef_sel};
        mul_b = {13'b0, coord_sel};
      end
      ST_SQA: begin
        mul_a = {2'b0, ax_r};
        mul_b = {2'b0, ax_r};
      end
      ST_SQB: begin
        mul_a = {2'b0, ay_r};
        mul_b = {2'b0, ay_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign add_idx = ms_r - 3'd1;

  // Accumulate the registered product into the sum that it belongs to
  always_comb begin
    case (add_idx[2:1])
      2'd0:    acc_sum = numx_r + prod_r[hre_pkg::ACC_W-1:0];
      2'd1:    acc_sum = numy_r + prod_r[hre_pkg::ACC_W-1:0];
      default: acc_sum = den_r + prod_r[hre_pkg::ACC_W-1:0];
    endcase
  end

  // Divider operands: magnitudes, sign handled on the quotient
  assign absx = numx_r[hre_pkg::ACC_W-1] ? -numx_r : numx_r;
  assign absy = numy_r[hre_pkg::ACC_W-1] ? -numy_r : numy_r;
  assign absd = den_r[hre_pkg::ACC_W-1] ? -den_r : den_r;

  assign fin_ok = (row0_xy_r[31:0] != hre_pkg::COEF_MINUS_ONE) &&
                  (pts_r != '0) && !bad_r;

  always_comb begin
    case (state_r)
      ST_DXS: begin
        div_dvd = {absx, 8'b0};
        div_dvs = absd;
      end
      ST_DYS: begin
        div_dvd = {absy, 8'b0};
        div_dvs = absd;
      end
      default: begin
        div_dvd = {8'b0, sum_r, 8'b0};
        div_dvs = hre_pkg::DVS_W'(pts_r);
      end
    endcase
  end

  assign div_start = (state_r == ST_DXS) || (state_r == ST_DYS) ||
                     ((state_r == ST_FIN) && fin_ok);

  hre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_quot),
    .stat     (div_st)
  );

  assign sq_trial = root_r + bit_r;
  assign sum_ext  = {1'b0, sum_r} + {17'b0, root_r[31:0]};

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row0_xy_r   <= 64'd65536;
      row0_off_r  <= 32'd0;
      row1_xy_r   <= 64'd281474976710656;
      row1_off_r  <= 32'd0;
      row2_xy_r   <= 64'd0;
      row2_off_r  <= 32'd65536;
      sum_r       <= '0;
      pts_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        case (cfg_index)
          hre_pkg::REG_ROW0_XY:  row0_xy_r  <= cfg_data;
          hre_pkg::REG_ROW0_OFF: row0_off_r <= cfg_data[31:0];
          hre_pkg::REG_ROW1_XY:  row1_xy_r  <= cfg_data;
          hre_pkg::REG_ROW1_OFF: row1_off_r <= cfg_data[31:0];
          hre_pkg::REG_ROW2_XY:  row2_xy_r  <= cfg_data;
          hre_pkg::REG_ROW2_OFF: row2_off_r <= cfg_data[31:0];
          default: ;
        endcase
      end

      // Drop the result word once taken, unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != ST_OUTW)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            x_r    <= in_first_x;
            y_r    <= in_first_y;
            sx_r   <= in_second_x;
            sy_r   <= in_second_y;
            last_r <= in_last;
            if (pts_r < hre_pkg::CNT_W'(hre_pkg::MAX_POINTS)) begin
              pts_r   <= pts_r + 1'b1;
              numx_r  <= {{16{row0_off_r[31]}}, row0_off_r, 8'b0};
              numy_r  <= {{16{row1_off_r[31]}}, row1_off_r, 8'b0};
              den_r   <= {{16{row2_off_r[31]}}, row2_off_r, 8'b0};
              ms_r    <= 3'd0;
              state_r <= ST_MUL;
            end else if (in_last) begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_MUL: begin
          if (ms_r != 3'd0) begin
            case (add_idx[2:1])
              2'd0:    numx_r <= acc_sum;
              2'd1:    numy_r <= acc_sum;
              default: den_r  <= acc_sum;
            endcase
          end
          ms_r <= ms_r + 3'd1;
          if (ms_r == 3'd6) begin
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (den_r == '0) begin
            bad_r   <= 1'b1;
            state_r <= ST_END;
          end else begin
            state_r <= ST_DXS;
          end
        end
        ST_DXS: state_r <= ST_DXW;
        ST_DXW: begin
          if (div_st.done) begin
            ax_r    <= diff_mag(sx_r, div_quot, div_st.ovf,
                                numx_r[hre_pkg::ACC_W-1] ^ den_r[hre_pkg::ACC_W-1]);
            state_r <= ST_DYS;
          end
        end
        ST_DYS: state_r <= ST_DYW;
        ST_DYW: begin
          if (div_st.done) begin
            ay_r    <= diff_mag(sy_r, div_quot, div_st.ovf,
                                numy_r[hre_pkg::ACC_W-1] ^ den_r[hre_pkg::ACC_W-1]);
            state_r <= ST_SQA;
          end
        end
        ST_SQA: state_r <= ST_SQB;
        ST_SQB: begin
          sq_r    <= prod_r[62:0];
          state_r <= ST_SQC;
        end
        ST_SQC: begin
          v_r     <= {1'b0, sq_r} + {1'b0, prod_r[62:0]};
          root_r  <= '0;
          bit_r   <= 64'h4000_0000_0000_0000;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          // One root bit a clock
          if (v_r >= sq_trial) begin
            v_r    <= v_r - sq_trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_r   <= sum_ext[hre_pkg::SUM_W] ? '1 : sum_ext[hre_pkg::SUM_W-1:0];
          state_r <= ST_END;
        end
        ST_END: state_r <= last_r ? ST_FIN : ST_IDLE;
        ST_FIN: begin
          vres_r <= fin_ok;
          if (fin_ok) begin
            state_r <= ST_MW;
          end else begin
            mean_r  <= '0;
            state_r <= ST_OUTW;
          end
        end
        ST_MW: begin
          if (div_st.done) begin
            mean_r  <= (div_st.ovf || div_quot[33:32] != 2'b0) ? '1 : div_quot[31:0];
            state_r <= ST_OUTW;
          end
        end
        ST_OUTW: begin
          // Hand the set result over and clear for the next set
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= mean_r;
            out_vres_r  <= vres_r;
            out_cnt_r   <= pts_r;
            sum_r       <= '0;
            pts_r       <= '0;
            bad_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_mean_error  = out_mean_r;
  assign out_valid_res   = out_vres_r;
  assign out_point_count = out_cnt_r;

`ifndef ASSERT_OFF
  a_pts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pts_r <= hre_pkg::CNT_W'(hre_pkg::MAX_POINTS))
    else $error("point count beyond limit");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_DXW || state_r == ST_DYW || state_r == ST_MW))
    else $error("divider finished outside a wait state");

  a_clear_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (pts_r == '0 && sum_r == '0 && !bad_r))
    else $error("set state not cleared with result");

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> root_r[63:32] == 32'b0)
    else $error("square root wider than 32 bits");
`endif

endmodule
